// File: rtl/bfca_pkg.sv
// ----------------------------------------------------------------------------
// bfca_pkg
// Types, codes and defaults shared by the best-fit allocator files.
// ----------------------------------------------------------------------------
package bfca_pkg;

	localparam int MaxFreeBlocksDefault = 64;
	localparam logic [31:0] RESET_REGION = 32'd65536;
	localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;
	localparam logic [1:0] OP_RESET = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	localparam logic [1:0] CFG_MODE   = 2'd0;
	localparam logic [1:0] CFG_BASE   = 2'd1;
	localparam logic [1:0] CFG_REGION = 2'd2;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] offset;
		logic [31:0] length;
	} in_t;

	typedef struct packed {
		logic [31:0] address;
		logic [1:0]  status;
	} out_t;

	typedef struct packed {
		logic [31:0] start;
		logic [31:0] len;
	} entry_t;

	typedef enum logic [1:0] {
		SH_NONE,
		SH_DEL,
		SH_INS
	} shift_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_EVAL,
		S_APPLY,
		S_FIN
	} state_t;

endpackage

// File: rtl/bfca_cell.sv
// ----------------------------------------------------------------------------
// bfca_cell
// One free-list entry: rotates along the ring, shifts, or takes a write.
// ----------------------------------------------------------------------------
module bfca_cell #(
	parameter int MAX_FREE_BLOCKS = bfca_pkg::MaxFreeBlocksDefault,
	parameter int IDX = 0
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 rot,
	input  bfca_pkg::shift_t                     shift,
	input  logic [$clog2(MAX_FREE_BLOCKS)-1:0]   sidx,
	input  logic                                 wr,
	input  logic [$clog2(MAX_FREE_BLOCKS)-1:0]   widx,
	input  bfca_pkg::entry_t                     wdata,
	input  bfca_pkg::entry_t                     next_e,
	input  bfca_pkg::entry_t                     prev_e,
	output bfca_pkg::entry_t                     e
);
	import bfca_pkg::*;

	localparam int IW = $clog2(MAX_FREE_BLOCKS);
	localparam logic [IW-1:0] MY = IW'(IDX);

	entry_t e_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_q.start <= '0;
			e_q.len   <= (IDX == 0) ? RESET_REGION : '0;
		end else if (rot) begin
			e_q <= next_e;
		end else if (shift == SH_DEL && MY >= sidx) begin
			e_q <= next_e;
		end else if (shift == SH_INS && MY > sidx) begin
			e_q <= prev_e;
		end else if (wr && MY == widx) begin
			e_q <= wdata;
		end
	end

	assign e = e_q;

endmodule

// File: rtl/best_fit_coalescing_allocator_core.sv
// ----------------------------------------------------------------------------
// best_fit_coalescing_allocator_core
// Bump or best-fit coalescing free-list suballocator over one region.
// ----------------------------------------------------------------------------
// One item at a time. Bump-mode requests, region resets and no-ops pass from
// acceptance through the apply and finish states to the registered result.
// Free-list allocate and free first scan the list: it lives in a ring of
// cells that rotates once past a single compare unit at cell 0, then an
// evaluate state checks merges and an apply state shifts, trims or inserts
// all cells at once. A new item is accepted once the previous result is
// registered; a result left waiting on the output holds the block until it
// is taken.
module best_fit_coalescing_allocator_core #(
	parameter int MAX_FREE_BLOCKS = bfca_pkg::MaxFreeBlocksDefault
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  bfca_pkg::in_t  in_item,
	output logic           out_valid,
	input  logic           out_ready,
	output bfca_pkg::out_t out_item,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_index,
	input  logic [31:0]    cfg_wdata
);
	import bfca_pkg::*;

	localparam int M  = MAX_FREE_BLOCKS;
	localparam int IW = $clog2(M);
	localparam int CW = $clog2(M + 1);
	localparam logic [CW-1:0] M_C = CW'(M);
	localparam logic [IW-1:0] LAST = IW'(M - 1);

	state_t state_q, state_d;

	logic        mode_q;
	logic [31:0] base_q, region_q, head_q;
	logic [CW-1:0] count_q;

	in_t          item_q;
	logic [IW-1:0] step_q;

	// scan results
	logic          found_q, lval_q;
	logic [IW-1:0] best_q;
	logic [CW-1:0] pos_q;
	logic [31:0]   least_q, bstart_q, ls_q, ll_q, rs_q, rl_q;
	logic          left_q;
	logic [31:0]   merged_q;

	out_t res_q;
	logic out_valid_q;
	out_t out_q;

	entry_t cells [M];
	entry_t head_e;

	logic    rot;
	shift_t  shift;
	logic [IW-1:0] sidx, widx;
	logic    wr;
	entry_t  wdata;

	assign head_e = cells[0];

	genvar g;
	generate
		for (g = 0; g < M; g++) begin : g_cell
			bfca_cell #(.MAX_FREE_BLOCKS(M), .IDX(g)) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.rot    (rot),
				.shift  (shift),
				.sidx   (sidx),
				.wr     (wr),
				.widx   (widx),
				.wdata  (wdata),
				.next_e (cells[(g + 1) % M]),
				.prev_e (cells[(g + M - 1) % M]),
				.e      (cells[g])
			);
		end
	endgenerate

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b1;
			base_q   <= '0;
			region_q <= RESET_REGION;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MODE:   mode_q   <= cfg_wdata[0];
				CFG_BASE:   base_q   <= cfg_wdata;
				CFG_REGION: region_q <= cfg_wdata;
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	// apply-cycle combinational results
	logic        right_c;
	logic [31:0] room_c;
	logic [CW-1:0] count_d;
	logic [31:0] head_d;
	out_t        res_d;

	always_comb begin
		state_d = state_q;
		rot     = 1'b0;
		shift   = SH_NONE;
		sidx    = '0;
		wr      = 1'b0;
		widx    = '0;
		wdata   = '0;
		count_d = count_q;
		head_d  = head_q;
		res_d   = '{address: 32'd0, status: ST_OK};
		room_c  = (head_q <= region_q) ? region_q - head_q : 32'd0;
		right_c = found_q &&
			((left_q ? ls_q + merged_q : item_q.offset + item_q.length) == rs_q);
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (mode_q && (in_item.operation == OP_ALLOC ||
						in_item.operation == OP_FREE))
						state_d = S_SCAN;
					else
						state_d = S_APPLY;
				end
			end
			S_SCAN: begin
				rot = 1'b1;
				if (step_q == LAST) state_d = S_EVAL;
			end
			S_EVAL: state_d = S_APPLY;
			S_APPLY: begin
				state_d = S_FIN;
				unique case (item_q.operation)
					OP_ALLOC: begin
						if (mode_q) begin
							if (!found_q) begin
								res_d = '{address: ALL_ONES, status: ST_NOSPACE};
							end else begin
								res_d.address = base_q + bstart_q;
								if (least_q == 32'd0) begin
									shift   = SH_DEL;
									sidx    = best_q;
									count_d = count_q - 1'b1;
								end else begin
									wr    = 1'b1;
									widx  = best_q;
									wdata = '{start: bstart_q + item_q.length, len: least_q};
								end
							end
						end else if (item_q.length > room_c) begin
							res_d = '{address: ALL_ONES, status: ST_NOSPACE};
						end else begin
							res_d.address = base_q + head_q;
							head_d = head_q + item_q.length;
						end
					end
					OP_FREE: begin
						if (mode_q) begin
							if (left_q && right_c) begin
								wr      = 1'b1;
								widx    = IW'(pos_q - 1'b1);
								wdata   = '{start: ls_q, len: merged_q + rl_q};
								shift   = SH_DEL;
								sidx    = pos_q[IW-1:0];
								count_d = count_q - 1'b1;
							end else if (left_q) begin
								wr    = 1'b1;
								widx  = IW'(pos_q - 1'b1);
								wdata = '{start: ls_q, len: merged_q};
							end else if (right_c) begin
								wr    = 1'b1;
								widx  = pos_q[IW-1:0];
								wdata = '{start: item_q.offset, len: rl_q + item_q.length};
							end else if (count_q >= M_C) begin
								res_d.status = ST_FULL;
							end else begin
								shift   = SH_INS;
								sidx    = pos_q[IW-1:0];
								wr      = 1'b1;
								widx    = pos_q[IW-1:0];
								wdata   = '{start: item_q.offset, len: item_q.length};
								count_d = count_q + 1'b1;
							end
						end
					end
					OP_RESET: begin
						if (mode_q) begin
							wr      = 1'b1;
							widx    = '0;
							wdata   = '{start: 32'd0, len: region_q};
							count_d = CW'(1);
						end else begin
							head_d = '0;
						end
					end
					default: ;
				endcase
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= CW'(1);
			head_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			head_q  <= head_d;
			if (state_q == S_FIN && (!out_valid_q || out_ready))
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && (!out_valid_q || out_ready)) out_q <= res_q;
		if (state_q == S_APPLY) res_q <= res_d;
	end

	// scan along the ring, one entry per cycle at cell 0
	logic        v_c;
	logic [31:0] diff_c;
	assign v_c    = CW'(step_q) < count_q;
	assign diff_c = head_e.len - item_q.length;

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				item_q  <= in_item;
				step_q  <= '0;
				found_q <= 1'b0;
				lval_q  <= 1'b0;
				pos_q   <= count_q;
			end
			S_SCAN: begin
				step_q <= step_q + 1'b1;
				if (item_q.operation == OP_ALLOC) begin
					if (v_c && head_e.len >= item_q.length && (!found_q || diff_c < least_q)) begin
						found_q  <= 1'b1;
						best_q   <= step_q;
						least_q  <= diff_c;
						bstart_q <= head_e.start;
					end
				end else if (v_c && !found_q) begin
					if (item_q.offset < head_e.start) begin
						found_q <= 1'b1;
						pos_q   <= CW'(step_q);
						rs_q    <= head_e.start;
						rl_q    <= head_e.len;
					end else begin
						lval_q <= 1'b1;
						ls_q   <= head_e.start;
						ll_q   <= head_e.len;
					end
				end
			end
			S_EVAL: begin
				left_q   <= lval_q && (ls_q + ll_q == item_q.offset);
				merged_q <= (lval_q && (ls_q + ll_q == item_q.offset)) ?
					ll_q + item_q.length : item_q.length;
			end
			default: ;
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= M_C) else $error("free-list count beyond capacity");

	a_count_only_apply: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_APPLY) |=> $stable(count_q)) else $error("count moved outside apply");

	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && step_q == LAST) |=> (state_q == S_EVAL))
		else $error("ring scan did not finish");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready) else $error("second item taken while busy");

endmodule
